>>> rtl/lz77_window_decompressor_defines.svh
// ----------------------------------------------------------------------------
// LZ77 window decompressor assertion macros
// Shared property wrappers for the checker. Each expects clk_i and rst_ni in
// the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LZ77_WINDOW_DECOMPRESSOR_DEFINES_SVH
`define LZ77_WINDOW_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication.
`define LZWD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LZWD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor package
// Word types, result kinds and parser codes shared by the design files.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

  localparam int unsigned LEN_W = 30;
  localparam int unsigned CNT_W = 5;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END_OK  = 2'd1;
  localparam logic [1:0] KIND_END_ERR = 2'd2;

  localparam logic [CNT_W-1:0] MATCH_MIN = 5'd3;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_ITEM,
    PH_MATCH2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_RD,
    ST_WR,
    ST_END
  } state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] total_len;
    logic             last;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lz77_window_decompressor.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor
// LZSS stream decoder with a history window held in a synchronous RAM.
// ----------------------------------------------------------------------------
// The compressed stream enters one word per handshake on the in channel; a
// word carries one byte and a flag marking the last byte of the stream.
// Decoded bytes and one end-of-stream report leave on the out channel, the
// report giving ok with the total length or error. The last flag marks the
// final output word caused by an input word.
// An input word is taken, decoded in the next cycle, and the block is ready
// again only once that word is fully handled: a literal waits for a free
// output slot, and no new word is taken while a match is copied. A match
// copies each byte through a history read followed by a write and emit. The
// end report is sent from its own state before the block is ready again.
// The output register lets a result wait while the next input word is taken.
// When the receiver stalls, decoding pauses at the next word to emit and
// nothing is lost. Reset clears the parser, count, error and limit; the
// history RAM is not cleared, as no read can reach an unwritten entry.
// The limit register is written on the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_window_decompressor
  import lzwd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_t              in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_word_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [LEN_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       ctrl_q, ctrl_d;
  logic [2:0]       bitpos_q, bitpos_d;
  logic [7:0]       mfb_q, mfb_d;
  logic             err_q, err_d;
  logic [LEN_W-1:0] prod_q, prod_d;
  logic [LEN_W-1:0] limit_q;
  logic [7:0]       byte_q, byte_d;
  logic             fin_q, fin_d;
  logic [AW-1:0]    src_q, src_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic             slot_free, active, flag, far, over, is_lit, is_copy, last_copy;
  logic [12:0]      offset;
  logic [CNT_W-1:0] length;

  assign slot_free = !out_valid_q || out_ready_i;
  assign active    = !err_q && (prod_q < limit_q);
  assign flag      = ctrl_q[bitpos_q];
  assign offset    = {1'b0, mfb_q[3:0], byte_q} + 13'd1;
  assign length    = {1'b0, mfb_q[7:4]} + MATCH_MIN;
  assign far       = {{(LEN_W-13){1'b0}}, offset} > prod_q;
  assign over      = ({1'b0, prod_q} + {{(LEN_W+1-CNT_W){1'b0}}, length}) > {1'b0, limit_q};
  assign is_lit    = active && (phase_q == PH_ITEM) && !flag;
  assign is_copy   = active && (phase_q == PH_MATCH2) && !far && !over;
  assign last_copy = (cnt_q == 5'd1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (is_lit) begin
          if (slot_free) begin
            state_d = fin_q ? ST_END : ST_IDLE;
          end
        end else if (is_copy) begin
          state_d = ST_RD;
        end else begin
          state_d = fin_q ? ST_END : ST_IDLE;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (slot_free) begin
          if (last_copy) begin
            state_d = fin_q ? ST_END : ST_IDLE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_END: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    ctrl_d      = ctrl_q;
    bitpos_d    = bitpos_q;
    mfb_d       = mfb_q;
    err_d       = err_q;
    prod_d      = prod_q;
    byte_d      = byte_q;
    fin_d       = fin_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = prod_q[AW-1:0];
    ram_wdata   = byte_q;
    ram_re      = 1'b0;
    ram_raddr   = src_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          byte_d = in_word_i.in_byte;
          fin_d  = in_word_i.final_byte;
        end
      end
      ST_DEC: begin
        if (active) begin
          case (phase_q)
            PH_CTRL: begin
              ctrl_d   = byte_q;
              bitpos_d = 3'd7;
              phase_d  = PH_ITEM;
            end
            PH_ITEM: begin
              if (flag) begin
                if (fin_q) begin
                  err_d = 1'b1;
                end else begin
                  mfb_d   = byte_q;
                  phase_d = PH_MATCH2;
                end
              end else if (slot_free) begin
                out_valid_d = 1'b1;
                out_d       = '{kind: KIND_DATA, out_byte: byte_q, total_len: '0,
                                last: !fin_q};
                ram_we      = 1'b1;
                prod_d      = prod_q + 30'd1;
                if (bitpos_q == 3'd0) begin
                  phase_d = PH_CTRL;
                end else begin
                  bitpos_d = bitpos_q - 3'd1;
                  phase_d  = PH_ITEM;
                end
              end
            end
            PH_MATCH2: begin
              if (far || over) begin
                err_d = 1'b1;
              end else begin
                cnt_d = length;
                src_d = prod_q[AW-1:0] - offset[AW-1:0];
              end
            end
            default: begin
              phase_d = PH_CTRL;
            end
          endcase
        end
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_WR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_DATA, out_byte: ram_rdata, total_len: '0,
                          last: last_copy && !fin_q};
          ram_we      = 1'b1;
          ram_wdata   = ram_rdata;
          prod_d      = prod_q + 30'd1;
          src_d       = src_q + 1'b1;
          cnt_d       = cnt_q - 5'd1;
          if (last_copy) begin
            if (bitpos_q == 3'd0) begin
              phase_d = PH_CTRL;
            end else begin
              bitpos_d = bitpos_q - 3'd1;
              phase_d  = PH_ITEM;
            end
          end
        end
      end
      ST_END: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: err_q ? KIND_END_ERR : KIND_END_OK, out_byte: 8'd0,
                          total_len: err_q ? '0 : prod_q, last: 1'b1};
          prod_d      = '0;
          phase_d     = PH_CTRL;
          ctrl_d      = 8'd0;
          bitpos_d    = 3'd7;
          mfb_d       = 8'd0;
          err_d       = 1'b0;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_CTRL;
      ctrl_q      <= 8'd0;
      bitpos_q    <= 3'd7;
      mfb_q       <= 8'd0;
      err_q       <= 1'b0;
      prod_q      <= '0;
      limit_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      ctrl_q      <= ctrl_d;
      bitpos_q    <= bitpos_d;
      mfb_q       <= mfb_d;
      err_q       <= err_d;
      prod_q      <= prod_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    fin_q  <= fin_d;
    src_q  <= src_d;
    out_q  <= out_d;
  end

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/lzwd_checker.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor checker
// Port-level properties of the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lz77_window_decompressor_defines.svh"

module lzwd_checker
  import lzwd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_word_o
);

  `LZWD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_word_o), "Stalled output word changed.")

  `LZWD_ASSERT_IMP(a_kind_code, out_valid_o,
                   out_word_o.kind == KIND_DATA || out_word_o.kind == KIND_END_OK ||
                   out_word_o.kind == KIND_END_ERR, "Output word carries an unused kind.")

  `LZWD_ASSERT_IMP(a_end_last, out_valid_o && out_word_o.kind != KIND_DATA,
                   out_word_o.last && out_word_o.out_byte == 8'd0,
                   "End report is not a clean final word.")

  `LZWD_ASSERT_IMP(a_err_len, out_valid_o && out_word_o.kind != KIND_END_OK,
                   out_word_o.total_len == '0, "Length reported outside an ok end.")

endmodule

bind lz77_window_decompressor lzwd_checker u_lzwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor testbench
// Feeds compressed streams through the block under random idling on both
// channels and checks every output word against a decoder kept alongside it.
// Directed streams cover literals, overlapping and maximum-length matches,
// offsets reaching before the start of the output, truncated matches, ends on
// a control byte and the output limit. Random phases then run well-formed
// streams with random content, cut-short streams and noise, under limit
// settings from zero to the largest value.
// ----------------------------------------------------------------------------
import lzwd_pkg::*;

class lzss_scoreboard;
  bit [7:0]       window [4096];
  bit [LEN_W-1:0] produced;
  bit [LEN_W-1:0] limit;
  phase_e         phase;
  bit [7:0]       ctrl;
  bit [7:0]       m1;
  bit [2:0]       pos;
  bit             err;
  out_t           decoded_words[$];
  int unsigned    fails;

  function new();
    limit = '0;
    fails = 0;
    restart();
  endfunction

  function void restart();
    produced = '0;
    phase    = PH_CTRL;
    ctrl     = '0;
    pos      = 3'd7;
    m1       = '0;
    err      = 1'b0;
  endfunction

  function void push_word(logic [1:0] k, bit [7:0] b, bit [LEN_W-1:0] n);
    out_t w;
    w.kind      = k;
    w.out_byte  = b;
    w.total_len = n;
    w.last      = 1'b0;
    decoded_words = {decoded_words, w};
  endfunction

  function void emit(bit [7:0] b);
    window[produced[11:0]] = b;
    produced = produced + 1'b1;
    push_word(KIND_DATA, b, '0);
  endfunction

  function void next_flag();
    if (pos == 3'd0) begin
      phase = PH_CTRL;
    end else begin
      pos   = pos - 1'b1;
      phase = PH_ITEM;
    end
  endfunction

  function void decode_word(in_t w);
    int unsigned before_n;
    int unsigned run;
    int unsigned offs;
    int unsigned k;
    bit [11:0]   src;
    before_n = decoded_words.size();
    if (!err && produced < limit) begin
      case (phase)
        PH_CTRL: begin
          ctrl  = w.in_byte;
          pos   = 3'd7;
          phase = PH_ITEM;
        end
        PH_ITEM: begin
          if (ctrl[pos]) begin
            if (w.final_byte) begin
              err = 1'b1;
            end else begin
              m1    = w.in_byte;
              phase = PH_MATCH2;
            end
          end else begin
            emit(w.in_byte);
            next_flag();
          end
        end
        default: begin
          run  = m1[7:4] + 3;
          offs = {m1[3:0], w.in_byte} + 1;
          if (offs > produced) begin
            err = 1'b1;
          end else if (produced + run > limit) begin
            err = 1'b1;
          end else begin
            for (k = 0; k < run; k++) begin
              src = 12'(produced - offs);
              emit(window[src]);
            end
            next_flag();
          end
        end
      endcase
    end
    if (w.final_byte) begin
      if (err) begin
        push_word(KIND_END_ERR, '0, '0);
      end else begin
        push_word(KIND_END_OK, '0, produced);
      end
      restart();
    end
    if (decoded_words.size() > before_n) begin
      decoded_words[decoded_words.size() - 1].last = 1'b1;
    end
  endfunction

  function void note_fail(string msg);
    fails++;
    if (fails <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  function void check_word(out_t got);
    out_t want;
    if (decoded_words.size() == 0) begin
      note_fail($sformatf("unexpected word kind=%0d byte=%02h len=%0d last=%0b",
                          got.kind, got.out_byte, got.total_len, got.last));
    end else begin
      want = decoded_words.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.total_len !== want.total_len || got.last !== want.last) begin
        note_fail($sformatf(
          "expected kind=%0d byte=%02h len=%0d last=%0b, got kind=%0d byte=%02h len=%0d last=%0b",
          want.kind, want.out_byte, want.total_len, want.last,
          got.kind, got.out_byte, got.total_len, got.last));
      end
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 50;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  in_t              in_word = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             in_ready;
  logic             out_valid;
  out_t             out_word;
  logic             cfg_ready;

  bit               calm_in = 1'b0;
  bit               calm_out = 1'b0;
  int unsigned      quiet = 0;
  lzss_scoreboard   sb;

  lz77_window_decompressor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_word(bit [7:0] b, bit fin);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {b, fin};
    do @(posedge clk); while (!in_ready);
    sb.decode_word(in_word);
  endtask

  task automatic send_stream(input bit [7:0] seq[$]);
    int unsigned i;
    for (i = 0; i < seq.size(); i++) begin
      send_word(seq[i], i == seq.size() - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.decoded_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(bit [LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.limit = v;
  endtask

  task automatic random_stream(output int unsigned n_sent);
    bit [7:0]    seq[$];
    bit [7:0]    ctl;
    bit [7:0]    hi;
    bit [7:0]    lo;
    int unsigned made;
    int unsigned groups;
    int unsigned f;
    int unsigned back_ref;
    int unsigned cut;
    made     = 0;
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) seq = {seq, 8'($urandom_range(0, 255))};
    end else begin
      groups = $urandom_range(1, 3);
      repeat (groups) begin
        ctl = 8'($urandom_range(0, 255));
        seq = {seq, ctl};
        for (f = 0; f < 8; f++) begin
          if (ctl[7 - f]) begin
            hi = 8'($urandom_range(0, 255));
            lo = 8'($urandom_range(0, 255));
            if (made > 0 && $urandom_range(0, 9) != 0) begin
              back_ref = $urandom_range(1, made > 4096 ? 4096 : made) - 1;
              hi[3:0] = back_ref[11:8];
              lo = back_ref[7:0];
            end
            seq = {seq, hi};
            seq = {seq, lo};
            made += hi[7:4] + 3;
          end else begin
            seq = {seq, 8'($urandom_range(0, 255))};
            made++;
          end
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, seq.size());
        while (seq.size() > cut) seq.delete(seq.size() - 1);
      end
    end
    n_sent = seq.size();
    send_stream(seq);
  endtask

  initial begin : drain
    int unsigned stall;
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_word);
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    bit [LEN_W-1:0] lim;
    int unsigned    counted;
    int unsigned    phase_no;
    int unsigned    n;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // With the limit still at its reset value every byte is ignored.
    send_stream('{8'hA5, 8'h5A});

    settle();
    set_limit(30'h3FFF_FFFF);
    send_stream('{8'h40, 8'h00, 8'hF0, 8'h00, 8'hFF, 8'h7F});
    send_stream('{8'h80, 8'h0F, 8'hFF, 8'h33, 8'h00});
    send_stream('{8'h40, 8'h11, 8'h2F});
    send_stream('{8'hFF});

    settle();
    set_limit(30'd2);
    send_stream('{8'h40, 8'h01, 8'h00, 8'h00});
    send_stream('{8'h00, 8'hC3, 8'h3C, 8'h99});

    counted  = 0;
    phase_no = 0;
    while (counted < 95 || phase_no < 4) begin
      case (phase_no % 4)
        0:       lim = 30'h3FFF_FFFF;
        1:       lim = 30'($urandom_range(1, 60));
        2:       lim = 30'($urandom_range(100, 400));
        default: lim = '0;
      endcase
      settle();
      set_limit(lim);
      random_stream(n);
      counted += n;
      phase_no++;
    end

    settle();
    if (sb.fails == 0 && sb.decoded_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lz77_window_decompressor.sv
rtl/lzwd_checker.sv
sim/tb_top.sv
